// ===== rtl/core/oate_pkg.sv =====
`timescale 1ns / 1ps

package oate_pkg;

    // Field widths of the request and response words.
    localparam int REQ_W   = 3;
    localparam int DATA_W  = 32;
    localparam int POS_W   = 7;
    localparam int STAT_W  = 3;
    localparam int INDEX_W = 6;
    localparam int COUNT_W = 7;

    // Request codes.
    localparam logic [REQ_W-1:0] REQ_CREATE  = 3'd0;
    localparam logic [REQ_W-1:0] REQ_DISPLAY = 3'd1;
    localparam logic [REQ_W-1:0] REQ_INSERT  = 3'd2;
    localparam logic [REQ_W-1:0] REQ_DELETE  = 3'd3;
    localparam logic [REQ_W-1:0] REQ_SEARCH  = 3'd4;

    // Status codes.
    localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
    localparam logic [STAT_W-1:0] ST_BAD_LEN   = 3'd1;
    localparam logic [STAT_W-1:0] ST_BAD_IDX   = 3'd2;
    localparam logic [STAT_W-1:0] ST_EMPTY     = 3'd3;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd4;
    localparam logic [STAT_W-1:0] ST_FULL_DROP = 3'd5;

    typedef struct packed {
        logic [REQ_W-1:0]         req_type;
        logic signed [DATA_W-1:0] value;
        logic [POS_W-1:0]         position;
        logic [POS_W-1:0]         length;
    } t_req;

    typedef struct packed {
        logic [STAT_W-1:0]        status;
        logic signed [DATA_W-1:0] data;
        logic [INDEX_W-1:0]       index;
        logic [COUNT_W-1:0]       count;
        logic                     last;
    } t_rsp;

    // Builds a single-word response with no data and no index.
    function automatic t_rsp make_rsp(input logic [STAT_W-1:0] status,
                                      input logic [COUNT_W-1:0] count);
        t_rsp r;
        r        = '0;
        r.status = status;
        r.count  = count;
        r.last   = 1'b1;
        return r;
    endfunction

endpackage

// ===== rtl/core/oate_store.sv =====
`timescale 1ns / 1ps

module oate_store #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic                         i_clk,
    input  logic                         i_we,
    input  logic [AW-1:0]                i_waddr,
    input  logic [oate_pkg::DATA_W-1:0]  i_wdata,
    input  logic [AW-1:0]                i_raddr,
    output logic [oate_pkg::DATA_W-1:0]  o_rdata
);

    logic [oate_pkg::DATA_W-1:0] r_mem [DEPTH];
    logic [oate_pkg::DATA_W-1:0] r_rdata;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/ordered_array_table_engine_core.sv =====
`timescale 1ns / 1ps

// Ordered table of up to CAPACITY signed 32-bit words held in one synchronous
// memory with a registered read, worked by a sequencer that takes one request
// at a time. Every walk that reads the table handles each entry as an address
// step, then a step on the registered read data, while create clears one entry
// per cycle. Results leave through an output register, so a finished response
// can wait on the consumer while the next request is already taken.
module ordered_array_table_engine_core #(
    parameter int CAPACITY = 64
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_req_valid,
    output logic             o_req_ready,
    input  oate_pkg::t_req   i_req,
    output logic             o_rsp_valid,
    input  logic             i_rsp_ready,
    output oate_pkg::t_rsp   o_rsp
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam logic [oate_pkg::COUNT_W-1:0] CAP_C = oate_pkg::COUNT_W'(CAPACITY);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_CRT      = 4'd1;
    localparam logic [3:0] S_DSP_RD   = 4'd2;
    localparam logic [3:0] S_DSP_EMIT = 4'd3;
    localparam logic [3:0] S_INS_RD   = 4'd4;
    localparam logic [3:0] S_INS_SH   = 4'd5;
    localparam logic [3:0] S_INS_PUT  = 4'd6;
    localparam logic [3:0] S_DEL_RD   = 4'd7;
    localparam logic [3:0] S_DEL_SH   = 4'd8;
    localparam logic [3:0] S_SRC_RD   = 4'd9;
    localparam logic [3:0] S_SRC_CMP  = 4'd10;
    localparam logic [3:0] S_RESP     = 4'd11;

    logic [3:0]                     r_state, n_state;
    logic [oate_pkg::COUNT_W-1:0]   r_count, n_count;
    logic [AW-1:0]                  r_ptr, n_ptr;
    logic [AW-1:0]                  r_pos, n_pos;
    logic [oate_pkg::DATA_W-1:0]    r_val, n_val;
    logic                           r_drop, n_drop;
    oate_pkg::t_rsp                 r_res, n_res;
    logic                           r_out_valid;
    oate_pkg::t_rsp                 r_out;

    logic                           mem_we;
    logic [AW-1:0]                  mem_waddr;
    logic [oate_pkg::DATA_W-1:0]    mem_wdata;
    logic [oate_pkg::DATA_W-1:0]    mem_rdata;

    logic                           slot_free;
    logic                           out_load;
    oate_pkg::t_rsp                 out_d;
    logic [oate_pkg::COUNT_W-1:0]   ins_cnt;
    logic                           ptr_at_end;

    // Element memory, read every cycle at the walk pointer.
    oate_store #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (r_ptr),
        .o_rdata (mem_rdata)
    );

    assign o_req_ready = (r_state == S_IDLE);
    assign slot_free   = !r_out_valid || i_rsp_ready;
    assign ins_cnt     = (r_count >= CAP_C) ? (CAP_C - 1'b1) : r_count;
    assign ptr_at_end  = ((oate_pkg::COUNT_W'(r_ptr) + 1'b1) == r_count);

    // Request sequencer.
    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_ptr     = r_ptr;
        n_pos     = r_pos;
        n_val     = r_val;
        n_drop    = r_drop;
        n_res     = r_res;
        mem_we    = 1'b0;
        mem_waddr = r_ptr;
        mem_wdata = '0;
        out_load  = 1'b0;
        out_d     = r_res;

        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    n_val = i_req.value;
                    unique case (i_req.req_type)
                        oate_pkg::REQ_CREATE: begin
                            if (i_req.length != '0 && i_req.length <= CAP_C) begin
                                n_count = i_req.length;
                                n_ptr   = '0;
                                n_state = S_CRT;
                            end else begin
                                n_count = '0;
                                n_res   = oate_pkg::make_rsp(oate_pkg::ST_BAD_LEN, '0);
                                n_state = S_RESP;
                            end
                        end
                        oate_pkg::REQ_DISPLAY: begin
                            if (r_count == '0) begin
                                n_res   = oate_pkg::make_rsp(oate_pkg::ST_EMPTY, '0);
                                n_state = S_RESP;
                            end else begin
                                n_ptr   = '0;
                                n_state = S_DSP_RD;
                            end
                        end
                        oate_pkg::REQ_INSERT: begin
                            // A full table loses its last entry before the insert.
                            n_drop  = (r_count >= CAP_C);
                            n_count = ins_cnt;
                            if (i_req.position > ins_cnt) begin
                                n_res   = oate_pkg::make_rsp(oate_pkg::ST_BAD_IDX, ins_cnt);
                                n_state = S_RESP;
                            end else begin
                                n_pos = AW'(i_req.position);
                                if (i_req.position == ins_cnt) begin
                                    n_state = S_INS_PUT;
                                end else begin
                                    n_ptr   = AW'(ins_cnt - 1'b1);
                                    n_state = S_INS_RD;
                                end
                            end
                        end
                        oate_pkg::REQ_DELETE: begin
                            if (r_count == '0) begin
                                n_res   = oate_pkg::make_rsp(oate_pkg::ST_EMPTY, '0);
                                n_state = S_RESP;
                            end else if (i_req.position >= r_count) begin
                                n_res   = oate_pkg::make_rsp(oate_pkg::ST_BAD_IDX, r_count);
                                n_state = S_RESP;
                            end else if ((i_req.position + 1'b1) == r_count) begin
                                // Removing the tail needs no shift.
                                n_count = r_count - 1'b1;
                                n_res   = oate_pkg::make_rsp(oate_pkg::ST_OK,
                                                             r_count - 1'b1);
                                n_state = S_RESP;
                            end else begin
                                n_ptr   = AW'(i_req.position + 1'b1);
                                n_state = S_DEL_RD;
                            end
                        end
                        oate_pkg::REQ_SEARCH: begin
                            if (r_count == '0) begin
                                n_res   = oate_pkg::make_rsp(oate_pkg::ST_NOT_FOUND, '0);
                                n_state = S_RESP;
                            end else begin
                                n_ptr   = '0;
                                n_state = S_SRC_RD;
                            end
                        end
                        default: begin
                            // Unused request codes are dropped silently.
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end

            // Clear entries 0 to count-1, one per cycle.
            S_CRT: begin
                mem_we    = 1'b1;
                mem_waddr = r_ptr;
                mem_wdata = '0;
                if (ptr_at_end) begin
                    n_res   = oate_pkg::make_rsp(oate_pkg::ST_OK, r_count);
                    n_state = S_RESP;
                end else begin
                    n_ptr = r_ptr + 1'b1;
                end
            end

            S_DSP_RD: begin
                n_state = S_DSP_EMIT;
            end

            // Stream one element per output word; read data holds while stalled.
            S_DSP_EMIT: begin
                if (slot_free) begin
                    out_load     = 1'b1;
                    out_d        = '0;
                    out_d.status = oate_pkg::ST_OK;
                    out_d.data   = mem_rdata;
                    out_d.index  = oate_pkg::INDEX_W'(r_ptr);
                    out_d.count  = r_count;
                    out_d.last   = ptr_at_end;
                    if (ptr_at_end) begin
                        n_state = S_IDLE;
                    end else begin
                        n_ptr   = r_ptr + 1'b1;
                        n_state = S_DSP_RD;
                    end
                end
            end

            S_INS_RD: begin
                n_state = S_INS_SH;
            end

            // Move entry ptr up to ptr+1, walking down toward the position.
            S_INS_SH: begin
                mem_we    = 1'b1;
                mem_waddr = r_ptr + 1'b1;
                mem_wdata = mem_rdata;
                if (r_ptr == r_pos) begin
                    n_state = S_INS_PUT;
                end else begin
                    n_ptr   = r_ptr - 1'b1;
                    n_state = S_INS_RD;
                end
            end

            S_INS_PUT: begin
                mem_we    = 1'b1;
                mem_waddr = r_pos;
                mem_wdata = r_val;
                n_count   = r_count + 1'b1;
                n_res     = oate_pkg::make_rsp(r_drop ? oate_pkg::ST_FULL_DROP
                                                      : oate_pkg::ST_OK,
                                               r_count + 1'b1);
                n_state   = S_RESP;
            end

            S_DEL_RD: begin
                n_state = S_DEL_SH;
            end

            // Move entry ptr down to ptr-1, walking up toward the tail.
            S_DEL_SH: begin
                mem_we    = 1'b1;
                mem_waddr = r_ptr - 1'b1;
                mem_wdata = mem_rdata;
                if (ptr_at_end) begin
                    n_count = r_count - 1'b1;
                    n_res   = oate_pkg::make_rsp(oate_pkg::ST_OK, r_count - 1'b1);
                    n_state = S_RESP;
                end else begin
                    n_ptr   = r_ptr + 1'b1;
                    n_state = S_DEL_RD;
                end
            end

            S_SRC_RD: begin
                n_state = S_SRC_CMP;
            end

            // Compare one entry against the key; first match wins.
            S_SRC_CMP: begin
                if (mem_rdata == r_val) begin
                    n_res       = oate_pkg::make_rsp(oate_pkg::ST_OK, r_count);
                    n_res.index = oate_pkg::INDEX_W'(r_ptr);
                    n_state     = S_RESP;
                end else if (ptr_at_end) begin
                    n_res   = oate_pkg::make_rsp(oate_pkg::ST_NOT_FOUND, r_count);
                    n_state = S_RESP;
                end else begin
                    n_ptr   = r_ptr + 1'b1;
                    n_state = S_SRC_RD;
                end
            end

            // Hand the single response word to the output register.
            S_RESP: begin
                if (slot_free) begin
                    out_load = 1'b1;
                    out_d    = r_res;
                    n_state  = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Working registers and the output word.
    always_ff @(posedge i_clk) begin
        r_ptr  <= n_ptr;
        r_pos  <= n_pos;
        r_val  <= n_val;
        r_drop <= n_drop;
        r_res  <= n_res;
        if (out_load) begin
            r_out <= out_d;
        end
    end

    assign o_rsp_valid = r_out_valid;
    assign o_rsp       = r_out;

    // The element count never exceeds the table size.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CAP_C)
        else $error("element count above capacity");

    // A dropped-tail insert always leaves the table full again.
    a_drop_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && o_rsp.status == oate_pkg::ST_FULL_DROP |-> o_rsp.count == CAP_C)
        else $error("full-drop response with table not full");

    // An empty answer is a single final word reporting no elements.
    a_empty_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && o_rsp.status == oate_pkg::ST_EMPTY |->
            o_rsp.last && o_rsp.count == '0)
        else $error("empty response malformed");

    // Only a display stream produces non-final words, and they are all ok.
    a_stream_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && !o_rsp.last |->
            o_rsp.status == oate_pkg::ST_OK &&
            (oate_pkg::COUNT_W'(o_rsp.index) + 1'b1) < o_rsp.count)
        else $error("non-final response word out of order");

endmodule
